/* rtl/c3d_pkg.sv */
// ---------------------------------------------------------------------------
// c3d_pkg
// Shared constants, register indexes, payload types and helpers for the
// curl 3D point transform.
// ---------------------------------------------------------------------------
`default_nettype none

package c3d_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int APB_AW        = 4;
  localparam int DATA_W        = 32;

  // Latency of the divider unit, in enabled cycles.
  localparam int DIV_LAT = 35;

  localparam logic [1:0] REG_WEIGHT = 2'd0;
  localparam logic [1:0] REG_COEF_X = 2'd1;
  localparam logic [1:0] REG_COEF_Y = 2'd2;
  localparam logic [1:0] REG_COEF_Z = 2'd3;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               zero_denominator;
    logic               saturated;
  } result_t;

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

endpackage

`default_nettype wire

/* rtl/c3d_stream_if.sv */
// ---------------------------------------------------------------------------
// c3d_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface c3d_stream_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* rtl/curl3d_point_transform_core.sv */
// ---------------------------------------------------------------------------
// curl3d_point_transform_core
// Curl 3D point transform in signed fixed point with saturation flags.
// ---------------------------------------------------------------------------
//   channel  | direction | transaction carries
//   point    | in        | in_x, in_y, in_z
//   result   | out       | out_x, out_y, out_z, zero_denominator, saturated
//   apb      | in/out    | weight, coef_x, coef_y, coef_z registers
//
// One point is accepted per cycle while the output buffer has room; each takes
// 14 arithmetic stages plus 35 divider stages (one quotient bit per step).
// A two-entry output buffer decouples the pipeline from the result channel;
// the pipeline advances whenever that buffer has room, so a stall holds all
// stages in place. Synchronous reset clears valid bits, the buffer count and
// the coefficient registers, and sets the weight register to one.
// ---------------------------------------------------------------------------
`default_nettype none

module curl3d_point_transform_core import c3d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  c3d_stream_if.sink          point,
  c3d_stream_if.source        result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int NMUL = 9;
  localparam int NSTG = 14;
  localparam logic [127:0] LOW_MASK = (128'd1 << FRAC_BITS) - 128'd1;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic        neg;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } mq_pp_t;

  typedef struct packed {
    logic         neg;
    logic [127:0] prod;
  } mq_ps_t;

  typedef struct packed {
    logic signed [63:0] val;
    logic               sat;
  } mq_res_t;

  function automatic mq_pp_t mq_pp(input logic signed [63:0] a,
                                   input logic signed [63:0] b);
    mq_pp_t      r;
    logic [63:0] ua;
    logic [63:0] ub;
    ua = mag64(a);
    ub = mag64(b);
    r.neg = a[63] ^ b[63];
    r.p00 = ua[31:0] * ub[31:0];
    r.p01 = ua[31:0] * ub[63:32];
    r.p10 = ua[63:32] * ub[31:0];
    r.p11 = ua[63:32] * ub[63:32];
    return r;
  endfunction

  function automatic mq_ps_t mq_sum(input mq_pp_t p);
    mq_ps_t r;
    r.neg  = p.neg;
    r.prod = {64'd0, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0}
           + {p.p11, 64'd0};
    return r;
  endfunction

  // Shift with rounding towards minus infinity, then clip to 64 bits.
  function automatic mq_res_t mq_fin(input mq_ps_t p);
    mq_res_t      r;
    logic [127:0] sh;
    sh = p.prod >> FRAC_BITS;
    if (p.neg && ((p.prod & LOW_MASK) != 128'd0)) sh = sh + 128'd1;
    if (p.neg) begin
      r.sat = (sh > 128'h8000_0000_0000_0000);
      r.val = r.sat ? S64_MIN : $signed(64'd0 - sh[63:0]);
    end else begin
      r.sat = (sh > 128'h7FFF_FFFF_FFFF_FFFF);
      r.val = r.sat ? S64_MAX : $signed(sh[63:0]);
    end
    return r;
  endfunction

  function automatic mq_res_t add_sat(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
    mq_res_t     r;
    logic [63:0] s;
    s = a + b;
    r.sat = (a[63] == b[63]) && (s[63] != a[63]);
    r.val = r.sat ? (b[63] ? S64_MIN : S64_MAX) : $signed(s);
    return r;
  endfunction

  function automatic mq_res_t sub_sat(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
    mq_res_t     r;
    logic [63:0] s;
    s = a - b;
    r.sat = (a[63] != b[63]) && (s[63] != a[63]);
    r.val = r.sat ? (b[63] ? S64_MAX : S64_MIN) : $signed(s);
    return r;
  endfunction

  // Configuration registers.
  logic signed [31:0] weight;
  logic signed [31:0] coef [3];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= 32'(ONE);
      coef[0] <= '0;
      coef[1] <= '0;
      coef[2] <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WEIGHT: weight  <= pwdata;
        REG_COEF_X: coef[0] <= pwdata;
        REG_COEF_Y: coef[1] <= pwdata;
        REG_COEF_Z: coef[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WEIGHT: prdata = weight;
      REG_COEF_X: prdata = coef[0];
      REG_COEF_Y: prdata = coef[1];
      REG_COEF_Z: prdata = coef[2];
      default:    prdata = '0;
    endcase
  end

  // Pipeline control.
  logic       en;
  logic [1:0] cnt;
  logic       vld  [NSTG];
  logic       dvld [DIV_LAT];
  logic       zl   [DIV_LAT];
  logic       sl   [DIV_LAT];

  assign en = (cnt != 2'd2);
  assign point.ready = en;

  // Stage registers.
  logic signed [31:0] pt1 [3];
  logic signed [63:0] pw1 [3];
  logic signed [63:0] pq1 [3];

  logic signed [31:0] pt2 [3];
  logic signed [63:0] c2  [3];
  logic signed [63:0] r2_2;

  logic signed [31:0] pt3 [3];
  mq_pp_t             pp3 [NMUL];

  logic signed [31:0] pt4 [3];
  mq_ps_t             ps4 [NMUL];

  logic signed [31:0] pt5 [3];
  logic signed [63:0] mv5 [NMUL];
  logic               sat5;
  logic signed [63:0] r2_3, r2_4, r2_5;

  logic signed [63:0] csum6, czz6, r2_6;
  logic signed [63:0] num6 [3];
  logic signed [63:0] t6   [3];
  logic               sat6;

  logic signed [63:0] csum7, r2_7;
  logic signed [63:0] num7 [3];
  logic signed [63:0] t7   [3];
  logic               sat7;

  mq_pp_t             pp8;
  logic signed [63:0] num8 [3];
  logic signed [63:0] t8   [3];
  logic               sat8;

  mq_ps_t             ps9;
  logic signed [63:0] num9 [3];
  logic signed [63:0] t9   [3];
  logic               sat9;

  logic signed [63:0] p10;
  logic signed [63:0] num10 [3];
  logic signed [63:0] t10   [3];
  logic               sat10;

  logic signed [63:0] d11, d12, d13, d14;
  logic signed [63:0] ty11, tz11, tz12;
  logic signed [63:0] num11 [3];
  logic signed [63:0] num12 [3];
  logic signed [63:0] num13 [3];
  logic signed [63:0] num14 [3];
  logic               sat11, sat12, sat13, sat14;

  // Clipping while the numerators are formed, kept apart from the rest.
  logic               nsat5, nsat6, nsat7, nsat8, nsat9;
  logic               nsat10, nsat11, nsat12, nsat13, nsat14;

  // Combinational stage logic.
  logic signed [63:0] ma [NMUL];
  logic signed [63:0] mb [NMUL];
  mq_res_t            fin5 [NMUL];
  mq_res_t            a6_csum;
  mq_res_t            a6_n [3];
  mq_res_t            a7, fin10, a11, a12, a13, a14;
  logic               any5, any6;
  logic               any5n, any6n;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i]   = c2[i];
      mb[i]   = c2[i];
      ma[3+i] = c2[i] + c2[i];
      mb[3+i] = 64'(pt2[i]);
      ma[6+i] = c2[i];
      mb[6+i] = r2_2;
    end
  end

  always_comb begin
    any5 = 1'b0;
    any5n = 1'b0;
    for (int i = 0; i < NMUL; i++) begin
      fin5[i] = mq_fin(ps4[i]);
      if (i < 6) any5 = any5 | fin5[i].sat;
      else any5n = any5n | fin5[i].sat;
    end
  end

  always_comb begin
    a6_csum = add_sat(mv5[0], mv5[1]);
    any6 = a6_csum.sat;
    any6n = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a6_n[i] = add_sat(64'(pt5[i]), mv5[6+i]);
      any6n = any6n | a6_n[i].sat;
    end
  end

  assign a7    = add_sat(csum6, czz6);
  assign fin10 = mq_fin(ps9);
  assign a11   = add_sat(p10, t10[0]);
  assign a12   = sub_sat(d11, ty11);
  assign a13   = add_sat(d12, tz12);
  assign a14   = add_sat(d13, ONE);

  always_ff @(posedge clk) begin
    if (en) begin
      pt1[0] <= point.data.in_x;
      pt1[1] <= point.data.in_y;
      pt1[2] <= point.data.in_z;
      pq1[0] <= point.data.in_x * point.data.in_x;
      pq1[1] <= point.data.in_y * point.data.in_y;
      pq1[2] <= point.data.in_z * point.data.in_z;
      for (int i = 0; i < 3; i++) begin
        pw1[i] <= weight * coef[i];
      end

      // Scaled coefficients and r2 cannot clip at 64 bits.
      for (int i = 0; i < 3; i++) begin
        pt2[i] <= pt1[i];
        c2[i]  <= pw1[i] >>> FRAC_BITS;
      end
      r2_2 <= (pq1[0] >>> FRAC_BITS) + (pq1[1] >>> FRAC_BITS)
            + (pq1[2] >>> FRAC_BITS);

      for (int i = 0; i < NMUL; i++) begin
        pp3[i]  <= mq_pp(ma[i], mb[i]);
        ps4[i]  <= mq_sum(pp3[i]);
        mv5[i]  <= fin5[i].val;
      end
      for (int i = 0; i < 3; i++) begin
        pt3[i] <= pt2[i];
        pt4[i] <= pt3[i];
        pt5[i] <= pt4[i];
      end
      r2_3 <= r2_2;
      r2_4 <= r2_3;
      r2_5 <= r2_4;
      sat5 <= any5;
      nsat5 <= any5n;

      csum6 <= a6_csum.val;
      czz6  <= mv5[2];
      r2_6  <= r2_5;
      sat6  <= sat5 | any6;
      nsat6 <= nsat5 | any6n;
      for (int i = 0; i < 3; i++) begin
        num6[i] <= a6_n[i].val;
        t6[i]   <= mv5[3+i];
      end

      csum7 <= a7.val;
      r2_7  <= r2_6;
      sat7  <= sat6 | a7.sat;
      pp8   <= mq_pp(r2_7, csum7);
      sat8  <= sat7;
      ps9   <= mq_sum(pp8);
      sat9  <= sat8;
      p10   <= fin10.val;
      sat10 <= sat9 | fin10.sat;
      nsat7  <= nsat6;
      nsat8  <= nsat7;
      nsat9  <= nsat8;
      nsat10 <= nsat9;
      nsat11 <= nsat10;
      nsat12 <= nsat11;
      nsat13 <= nsat12;
      nsat14 <= nsat13;
      for (int i = 0; i < 3; i++) begin
        num7[i]  <= num6[i];
        t7[i]    <= t6[i];
        num8[i]  <= num7[i];
        t8[i]    <= t7[i];
        num9[i]  <= num8[i];
        t9[i]    <= t8[i];
        num10[i] <= num9[i];
        t10[i]   <= t9[i];
        num11[i] <= num10[i];
        num12[i] <= num11[i];
        num13[i] <= num12[i];
        num14[i] <= num13[i];
      end

      // The denominator is built term by term, each add clipping on its own.
      d11   <= a11.val;
      ty11  <= t10[1];
      tz11  <= t10[2];
      sat11 <= sat10 | a11.sat;
      d12   <= a12.val;
      tz12  <= tz11;
      sat12 <= sat11 | a12.sat;
      d13   <= a13.val;
      sat13 <= sat12 | a13.sat;
      d14   <= a14.val;
      sat14 <= sat13 | a14.sat;

      // Numerator clipping only counts when there is a division to do.
      zl[0] <= (d14 == 64'sd0);
      sl[0] <= sat14 | ((d14 != 64'sd0) & nsat14);
      for (int k = 1; k < DIV_LAT; k++) begin
        zl[k] <= zl[k-1];
        sl[k] <= sl[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) vld[k] <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) dvld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= point.valid;
      for (int k = 1; k < NSTG; k++) vld[k] <= vld[k-1];
      dvld[0] <= vld[NSTG-1];
      for (int k = 1; k < DIV_LAT; k++) dvld[k] <= dvld[k-1];
    end
  end

  logic signed [31:0] quo [3];
  logic               dovf [3];

  c3d_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .num(num14[0]), .den(d14), .quo(quo[0]), .ovf(dovf[0])
  );
  c3d_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .num(num14[1]), .den(d14), .quo(quo[1]), .ovf(dovf[1])
  );
  c3d_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk(clk), .en(en), .num(num14[2]), .den(d14), .quo(quo[2]), .ovf(dovf[2])
  );

  // A zero denominator forces zero outputs and hides the divider's flag.
  result_t res;
  logic    zero;

  assign zero = zl[DIV_LAT-1];
  assign res.out_x = zero ? 32'sd0 : quo[0];
  assign res.out_y = zero ? 32'sd0 : quo[1];
  assign res.out_z = zero ? 32'sd0 : quo[2];
  assign res.zero_denominator = zero;
  assign res.saturated = sl[DIV_LAT-1] | (!zero & (dovf[0] | dovf[1] | dovf[2]));

  // Two-entry output buffer.
  result_t f0, f1;
  logic    push, pop;

  assign push = en & dvld[DIV_LAT-1];
  assign pop  = (cnt != 2'd0) & result.ready;
  assign result.valid = (cnt != 2'd0);
  assign result.data  = f0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: cnt <= cnt + 2'd1;
        2'b01: cnt <= cnt - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) f0 <= res;
        else f1 <= res;
      end
      2'b01: f0 <= f1;
      2'b11: f0 <= res;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/c3d_div.sv */
// ---------------------------------------------------------------------------
// c3d_div
// Pipelined signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// towards zero and saturated to 32 bits, one quotient bit per step.
// ---------------------------------------------------------------------------
`default_nettype none

module c3d_div import c3d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic signed [31:0] quo,
  output logic               ovf
);

  localparam int STEPS = 32;
  localparam int HI_SH = 32 - FRAC_BITS;

  logic        neg1;
  logic [63:0] n1;
  logic [63:0] d1;

  logic        neg_s [STEPS+1];
  logic        big_s [STEPS+1];
  logic [63:0] dm_s  [STEPS+1];
  logic [63:0] rem_s [STEPS+1];
  logic [31:0] low_s [STEPS+1];
  logic [31:0] q_s   [STEPS+1];

  logic [63:0] rem_next [STEPS];
  logic [31:0] q_next   [STEPS];

  logic [31:0] lim;
  logic        over;
  logic [31:0] qm;

  // Each step shifts in one dividend bit and makes one trial subtraction.
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      logic [64:0] cand;
      logic        ge;
      cand = {rem_s[k], low_s[k][31]};
      ge = (cand >= {1'b0, dm_s[k]});
      rem_next[k] = ge ? 64'(cand - {1'b0, dm_s[k]}) : cand[63:0];
      q_next[k]   = {q_s[k][30:0], ge};
    end
  end

  assign lim  = neg_s[STEPS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign over = big_s[STEPS] || (q_s[STEPS] > lim);
  assign qm   = over ? lim : q_s[STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= num[63] ^ den[63];
      n1   <= mag64(num);
      d1   <= mag64(den);

      // A quotient of 2^32 or more always saturates, so only 32 bits are
      // developed; the top part of the dividend seeds the remainder.
      neg_s[0] <= neg1;
      big_s[0] <= ({32'd0, n1} >= ({32'd0, d1} << HI_SH));
      dm_s[0]  <= d1;
      rem_s[0] <= n1 >> HI_SH;
      low_s[0] <= 32'(n1 << FRAC_BITS);
      q_s[0]   <= '0;

      for (int k = 0; k < STEPS; k++) begin
        neg_s[k+1] <= neg_s[k];
        big_s[k+1] <= big_s[k];
        dm_s[k+1]  <= dm_s[k];
        rem_s[k+1] <= rem_next[k];
        low_s[k+1] <= {low_s[k][30:0], 1'b0};
        q_s[k+1]   <= q_next[k];
      end

      ovf <= over;
      quo <= neg_s[STEPS] ? $signed(32'd0 - qm) : $signed(qm);
    end
  end

endmodule

`default_nettype wire

/* dv/tb_curl3d_point_transform_core.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_curl3d_point_transform_core
// Self-checking testbench for the curl 3D point transform. A short table of
// directed points and register writes is followed by random phases, each
// with its own register setting. Accepted points with no fixed result use a
// fixed-point predictor; all results are checked in order, with random
// stalls on both channels, a long receiver hold and drains between phases.
// ---------------------------------------------------------------------------

module tb_curl3d_point_transform_core;
  import c3d_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE = 60;
  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [129:0] HI64 = (130'sd1 <<< 63) - 130'sd1;
  localparam logic signed [129:0] LO64 = -(130'sd1 <<< 63);
  localparam logic signed [129:0] HI32 = (130'sd1 <<< 31) - 130'sd1;
  localparam logic signed [129:0] LO32 = -(130'sd1 <<< 31);

  typedef logic signed [63:0] s64_t;

  typedef struct {
    bit          wr;
    logic [1:0]  idx;
    logic [31:0] val;
    point_t      pt;
    bit          typed;
    result_t     res;
  } step_t;

  typedef struct {
    bit      typed;
    result_t res;
  } offer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  c3d_stream_if #(.payload_t(point_t))  point_ch ();
  c3d_stream_if #(.payload_t(result_t)) result_ch ();

  curl3d_point_transform_core dut (
    .clk(clk), .rst(rst), .point(point_ch), .result(result_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [31:0] cfg [4];
  result_t pending_results[$];
  offer_t  offered[$];
  step_t   plan[$];
  int      errors = 0;
  int      idle_cycles = 0;
  int      hold_left = 0;
  bit      quiet = 1'b0;
  bit      clipped;

  // ---- fixed-point predictor ------------------------------------------------
  function automatic s64_t sat64(input logic signed [129:0] v);
    if (v > HI64) begin clipped = 1'b1; return HI64[63:0]; end
    if (v < LO64) begin clipped = 1'b1; return LO64[63:0]; end
    return v[63:0];
  endfunction

  function automatic s64_t qmul(input s64_t a, input s64_t b);
    logic signed [129:0] wa, wb;
    wa = a;
    wb = b;
    return sat64((wa * wb) >>> FRAC);
  endfunction

  function automatic s64_t qadd(input s64_t a, input s64_t b);
    logic signed [129:0] wa, wb;
    wa = a;
    wb = b;
    return sat64(wa + wb);
  endfunction

  function automatic s64_t qsub(input s64_t a, input s64_t b);
    logic signed [129:0] wa, wb;
    wa = a;
    wb = b;
    return sat64(wa - wb);
  endfunction

  // Quotient truncates toward zero, then clips to the 32-bit output range.
  function automatic logic [31:0] qdiv(input s64_t num, input s64_t den);
    logic signed [129:0] n, dd, q;
    n = num;
    dd = den;
    q = (n <<< FRAC) / dd;
    if (q > HI32) begin clipped = 1'b1; return QMAX; end
    if (q < LO32) begin clipped = 1'b1; return QMIN; end
    return q[31:0];
  endfunction

  function automatic result_t curl_predict(input point_t p);
    s64_t x, y, z, w, cx, cy, cz, csum, r2, den;
    result_t r;
    clipped = 1'b0;
    x = p.in_x;
    y = p.in_y;
    z = p.in_z;
    w = cfg[REG_WEIGHT];
    cx = qmul(w, s64_t'(cfg[REG_COEF_X]));
    cy = qmul(w, s64_t'(cfg[REG_COEF_Y]));
    cz = qmul(w, s64_t'(cfg[REG_COEF_Z]));
    csum = qadd(qadd(qmul(cx, cx), qmul(cy, cy)), qmul(cz, cz));
    r2 = qadd(qadd(qmul(x, x), qmul(y, y)), qmul(z, z));
    den = qmul(r2, csum);
    den = qadd(den, qmul(cx + cx, x));
    // The y term is subtracted.
    den = qsub(den, qmul(cy + cy, y));
    den = qadd(den, qmul(cz + cz, z));
    den = qadd(den, s64_t'(1) <<< FRAC);
    r = '0;
    r.zero_denominator = (den == 0);
    if (den != 0) begin
      r.out_x = qdiv(qadd(x, qmul(cx, r2)), den);
      r.out_y = qdiv(qadd(y, qmul(cy, r2)), den);
      r.out_z = qdiv(qadd(z, qmul(cz, r2)), den);
    end
    r.saturated = clipped;
    return r;
  endfunction

  // ---- checking -------------------------------------------------------------
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    offer_t o;
    result_t e, g;
    if (!rst) begin
      if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (point_ch.valid && point_ch.ready) begin
        o = offered.pop_front();
        pending_results.push_back(o.typed ? o.res : curl_predict(point_ch.data));
      end
      if (result_ch.valid && result_ch.ready) begin
        g = result_ch.data;
        if (pending_results.size() == 0) begin
          report("unexpected result transaction", g.out_x, '0);
        end else begin
          e = pending_results.pop_front();
          if (g.out_x !== e.out_x) report("out_x", g.out_x, e.out_x);
          if (g.out_y !== e.out_y) report("out_y", g.out_y, e.out_y);
          if (g.out_z !== e.out_z) report("out_z", g.out_z, e.out_z);
          if (g.zero_denominator !== e.zero_denominator)
            report("zero_denominator", 32'(g.zero_denominator), 32'(e.zero_denominator));
          if (g.saturated !== e.saturated)
            report("saturated", 32'(g.saturated), 32'(e.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---- result receiver: random stalls, plus long holds on request ----------
  initial begin
    int stall;
    stall = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        result_ch.ready <= 1'b0;
      end else begin
        if (!quiet && $urandom_range(0, 5) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---- stimulus helpers -----------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (quiet || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 524288) - 262144;
      6, 7: return $urandom;
      8: begin
        case ($urandom_range(0, 4))
          0: return QMAX;
          1: return QMIN;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
      default: return $urandom_range(0, 33554432) - 16777216;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 262144) - 131072;
  endfunction

  task automatic send_point(input point_t p, input bit typed, input result_t res);
    offer_t o;
    int gap;
    o.typed = typed;
    o.res = res;
    offered.push_back(o);
    point_ch.valid <= 1'b1;
    point_ch.data <= p;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    point_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || offered.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one register and reads it back; only called while the block is idle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cfg[idx] = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== val) report("register read-back", prdata, val);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void plan_write(input logic [1:0] idx, input logic [31:0] val);
    step_t s;
    s = '{default: '0};
    s.wr = 1'b1;
    s.idx = idx;
    s.val = val;
    plan.push_back(s);
  endfunction

  function automatic void plan_point(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z);
    step_t s;
    s = '{default: '0};
    s.pt = '{x, y, z};
    plan.push_back(s);
  endfunction

  function automatic void plan_fixed(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z, input logic [31:0] ox,
                                     input logic [31:0] oy, input logic [31:0] oz,
                                     input logic zd);
    step_t s;
    s = '{default: '0};
    s.pt = '{x, y, z};
    s.typed = 1'b1;
    s.res = '{ox, oy, oz, zd, 1'b0};
    plan.push_back(s);
  endfunction

  // ---- main sequence --------------------------------------------------------
  initial begin
    point_t p;
    bit was_write;
    point_ch.valid = 1'b0;
    point_ch.data = '0;
    cfg[REG_WEIGHT] = ONE;
    cfg[REG_COEF_X] = '0;
    cfg[REG_COEF_Y] = '0;
    cfg[REG_COEF_Z] = '0;

    // Reset values pass points through unchanged.
    plan_fixed(0, 0, 0, 0, 0, 0, 1'b0);
    plan_fixed(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0);
    plan_fixed(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b0);
    plan_fixed(1, -1, 32'h8000, 1, -1, 32'h8000, 1'b0);
    // Denominator vanishes on each axis in turn, the y axis with opposite sign.
    plan_write(REG_COEF_X, ONE);
    plan_fixed(-ONE, 0, 0, 0, 0, 0, 1'b1);
    plan_point(ONE, 0, 0);
    plan_point(0, ONE, -ONE);
    plan_write(REG_COEF_X, 0);
    plan_write(REG_COEF_Y, ONE);
    plan_fixed(0, ONE, 0, 0, 0, 0, 1'b1);
    plan_point(0, -ONE, ONE);
    plan_write(REG_COEF_Y, 0);
    plan_write(REG_COEF_Z, ONE);
    plan_fixed(0, 0, -ONE, 0, 0, 0, 1'b1);
    plan_point(QMAX, QMIN, 32'h3_0000);
    // Extreme weights and coefficients clip the intermediates.
    plan_write(REG_WEIGHT, QMAX);
    plan_write(REG_COEF_X, QMAX);
    plan_write(REG_COEF_Y, QMIN);
    plan_write(REG_COEF_Z, QMAX);
    plan_point(ONE, ONE, ONE);
    plan_point(QMAX, QMIN, 0);
    plan_point(0, 0, 0);
    plan_write(REG_WEIGHT, QMIN);
    plan_point(-ONE, 2, QMIN);
    plan_point(32'h0000_8000, 32'hFFFF_8000, 1);
    // Zero weight cancels the coefficients.
    plan_write(REG_WEIGHT, 0);
    plan_fixed(32'h1234_5678, 32'h8765_4321, -5, 32'h1234_5678, 32'h8765_4321, -5, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    was_write = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].wr) begin
        if (!was_write) drain();
        reg_write(plan[i].idx, plan[i].val);
      end else begin
        send_point(plan[i].pt, plan[i].typed, plan[i].res);
      end
      was_write = plan[i].wr;
    end

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: begin
          reg_write(REG_WEIGHT, QMAX); reg_write(REG_COEF_X, QMIN);
          reg_write(REG_COEF_Y, QMAX); reg_write(REG_COEF_Z, QMIN);
        end
        1: begin
          reg_write(REG_WEIGHT, QMIN); reg_write(REG_COEF_X, QMAX);
          reg_write(REG_COEF_Y, 0); reg_write(REG_COEF_Z, 1);
        end
        default: begin
          reg_write(REG_WEIGHT, rand_coef()); reg_write(REG_COEF_X, rand_coef());
          reg_write(REG_COEF_Y, rand_coef()); reg_write(REG_COEF_Z, rand_coef());
        end
      endcase
      quiet = (ph == 4 || ph == 6);
      // Hold the receiver off while points keep coming, so the pipeline backs up.
      if (ph == 6) hold_left = 400;
      for (int k = 0; k < 82; k++) begin
        p = '{rand_coord(), rand_coord(), rand_coord()};
        send_point(p, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
